// ===== hdl/pwhr_pkg.sv =====
// pwhr_pkg: shared types and fixed constants for the pulse window heart rate core
// no dependencies; imported by pulse_window_heart_rate_core and its bench
`default_nettype none

package pwhr_pkg;

    localparam int TIME_W        = 32;     // millisecond timestamp width
    localparam int GAP_W         = 16;     // max gap register width
    localparam int BPM_W         = 21;     // rate field width
    localparam int CNT_W         = 5;      // beat index width
    localparam int IN_TDATA_W    = 32;
    localparam int OUT_TDATA_W   = 32;
    localparam int OUT_TUSER_W   = 2;
    localparam int MS_PER_MINUTE = 60000;

    localparam logic [GAP_W-1:0] GAP_RESET = 16'd2000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } t_state;

    // control strobes decoded from the state
    typedef struct packed {
        logic in_ready;
        logic div_run;
        logic emit_load;
    } t_ctrl;

endpackage

`default_nettype wire

// ===== hdl/pulse_window_heart_rate_core.sv =====
// pulse_window_heart_rate_core: heart rate from the average period over BEATS intervals
// an item that closes a window with a nonzero span runs the bit-serial restoring divider
//   for QW quotient bits (QW = bits of 60000*BEATS, 21 at BEATS=20) before its result loads
// a new item is taken only once the previous result has been loaded into the output register
// reset: synchronous active-low; max gap to 2000 ms, times, count and held rate to 0
// depends on pwhr_pkg
`default_nettype none

module pulse_window_heart_rate_core #(
    parameter int BEATS = 20
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration: max_gap_ms
    input  wire logic                              i_cfg_we,
    input  wire logic [pwhr_pkg::GAP_W-1:0]        i_cfg_wdata,
    // input items
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    input  wire logic [pwhr_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,   // [31:0] pulse_time_ms
    // result items
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    output logic [pwhr_pkg::OUT_TDATA_W-1:0]       o_m_axis_tdata,   // [20:0] bpm,
                                                                     // [25:21] beat_index,
                                                                     // [31:26] zero
    output logic [pwhr_pkg::OUT_TUSER_W-1:0]       o_m_axis_tuser    // [0] bpm_new,
                                                                     // [1] gap_error
);
    import pwhr_pkg::*;

    localparam int unsigned FULL = MS_PER_MINUTE * BEATS;
    localparam int          QW   = $clog2(FULL + 1);
    localparam int          DCW  = $clog2(QW);

    t_state r_state, n_state;
    t_ctrl  ctrl;

    logic [GAP_W-1:0]  r_max_gap;
    logic [TIME_W-1:0] r_last, r_start;
    logic [CNT_W-1:0]  r_count;
    logic [BPM_W-1:0]  r_held_bpm;
    logic              r_res_new, r_res_err;

    logic [QW-1:0]     r_quo, n_quo;
    logic [TIME_W-1:0] r_rem, n_rem;
    logic [TIME_W-1:0] r_span;
    logic [DCW-1:0]    r_div_cnt;

    logic                   r_o_valid;
    logic [OUT_TDATA_W-1:0] r_o_data;
    logic [OUT_TUSER_W-1:0] r_o_user;

    logic              in_acc;
    logic [TIME_W-1:0] now, gap, span;
    logic              gap_err, win_done;
    logic [TIME_W+1:0] trial;
    logic              qbit;

    assign now      = i_s_axis_tdata[TIME_W-1:0];
    assign gap      = now - r_last;
    assign span     = now - r_start;
    assign gap_err  = gap > {{(TIME_W-GAP_W){1'b0}}, r_max_gap};
    assign win_done = !gap_err && (r_count >= CNT_W'(BEATS));
    assign in_acc   = i_s_axis_tvalid && ctrl.in_ready;

    // one quotient bit per cycle: shift next dividend bit into the remainder
    assign trial = {1'b0, r_rem, r_quo[QW-1]} - {2'b00, r_span};
    assign qbit  = !trial[TIME_W+1];
    assign n_rem = qbit ? trial[TIME_W-1:0] : {r_rem[TIME_W-2:0], r_quo[QW-1]};
    assign n_quo = {r_quo[QW-2:0], qbit};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    // a zero span saturates without dividing
                    if (win_done && (span != '0)) begin
                        n_state = ST_DIV;
                    end else begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_DIV: begin
                if (r_div_cnt == '0) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (ctrl.emit_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        ctrl = '0;
        case (r_state)
            ST_IDLE: ctrl.in_ready = 1'b1;
            ST_DIV:  ctrl.div_run  = 1'b1;
            ST_EMIT: ctrl.emit_load = !r_o_valid || i_m_axis_tready;
            default: ctrl = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_max_gap  <= GAP_RESET;
            r_last     <= '0;
            r_start    <= '0;
            r_count    <= '0;
            r_held_bpm <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_max_gap <= i_cfg_wdata;
            end
            if (in_acc) begin
                r_last <= now;
                if (gap_err) begin
                    r_count <= '0;
                end else begin
                    if (r_count == '0) begin
                        r_start <= now;
                    end
                    if (win_done) begin
                        r_count <= '0;
                        if (span == '0) begin
                            r_held_bpm <= BPM_W'(FULL);
                        end
                    end else begin
                        r_count <= r_count + 1'b1;
                    end
                end
            end
            if (ctrl.div_run && (r_div_cnt == '0)) begin
                r_held_bpm <= BPM_W'(n_quo);
            end
            if (ctrl.emit_load) begin
                r_o_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_res_err <= gap_err;
            r_res_new <= win_done;
            r_quo     <= QW'(FULL);
            r_rem     <= '0;
            r_span    <= span;
            r_div_cnt <= DCW'(QW - 1);
        end
        if (ctrl.div_run) begin
            r_quo     <= n_quo;
            r_rem     <= n_rem;
            r_div_cnt <= r_div_cnt - 1'b1;
        end
        if (ctrl.emit_load) begin
            r_o_data <= {{(OUT_TDATA_W-BPM_W-CNT_W){1'b0}}, r_count, r_held_bpm};
            r_o_user <= {r_res_err, r_res_new};
        end
    end

    assign o_s_axis_tready = ctrl.in_ready;
    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = r_o_data;
    assign o_m_axis_tuser  = r_o_user;

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != ST_IDLE))
        else $error("state did not leave idle after an item");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(BEATS))
        else $error("beat count past window length");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> !(r_o_user[0] && r_o_user[1]))
        else $error("result marks both new rate and gap error");

    a_flag_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && (r_o_user[0] || r_o_user[1])) |-> (r_o_data[BPM_W+CNT_W-1:BPM_W] == '0))
        else $error("beat index not cleared on completion or error");

    a_bpm_update_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_held_bpm) |-> ($past(ctrl.div_run) || $past(in_acc)))
        else $error("held rate changed outside an item or a division");

endmodule

`default_nettype wire

// ===== tb/sv/pulse_window_heart_rate_core_tb.sv =====
// pulse_window_heart_rate_core_tb: self-checking bench for the pulse window heart rate core
// predicts each result from pulse edge times and the max gap register, with random stalls
// depends on pwhr_pkg and pulse_window_heart_rate_core
module pulse_window_heart_rate_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pwhr_pkg::*;

    localparam int WINDOW_BEATS = 20;
    localparam logic [31:0] FULL_RATE = MS_PER_MINUTE * WINDOW_BEATS;

    typedef struct packed {
        logic              bpm_new;
        logic [BPM_W-1:0]  bpm;
        logic              gap_error;
        logic [CNT_W-1:0]  beat_index;
    } t_pulse_result;

    // tracks the window the block should be in and the results it owes
    class t_pulse_rate_checker;
        logic [GAP_W-1:0]  gap_limit;
        logic [TIME_W-1:0] window_start;
        logic [TIME_W-1:0] last_edge;
        logic [CNT_W-1:0]  edge_count;
        logic [BPM_W-1:0]  held_bpm;
        t_pulse_result     owed_results[$];
        int                mismatches;
        int                edges;
        int                windows;
        int                restarts;

        function void clear();
            gap_limit    = GAP_RESET;
            window_start = '0;
            last_edge    = '0;
            edge_count   = '0;
            held_bpm     = '0;
            owed_results.delete();
            mismatches   = 0;
            edges        = 0;
            windows      = 0;
            restarts     = 0;
        endfunction

        function logic [BPM_W-1:0] rate_for_span(logic [TIME_W-1:0] span);
            logic [31:0] q;
            q = (span == 0) ? FULL_RATE : FULL_RATE / span;
            return q[BPM_W-1:0];
        endfunction

        function void take_pulse(logic [TIME_W-1:0] now);
            logic [TIME_W-1:0] gap;
            t_pulse_result     r;
            gap         = now - last_edge;
            r.bpm_new   = 1'b0;
            r.gap_error = 1'b0;
            edges++;
            if (gap > {16'd0, gap_limit}) begin
                r.gap_error = 1'b1;
                edge_count  = '0;
                last_edge   = now;
                restarts++;
            end else begin
                if (edge_count == 0)
                    window_start = now;
                last_edge = now;
                if (edge_count >= WINDOW_BEATS) begin
                    held_bpm   = rate_for_span(now - window_start);
                    edge_count = '0;
                    r.bpm_new  = 1'b1;
                    windows++;
                end else begin
                    edge_count = edge_count + 1'b1;
                end
            end
            r.bpm        = held_bpm;
            r.beat_index = edge_count;
            owed_results.push_back(r);
        endfunction

        function void match_result(t_pulse_result got);
            t_pulse_result want;
            if (owed_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] result with no edge pending: new=%0d bpm=%0d err=%0d idx=%0d",
                             $realtime, got.bpm_new, got.bpm, got.gap_error,
                             got.beat_index);
                return;
            end
            want = owed_results.pop_front();
            if (got.bpm_new !== want.bpm_new || got.bpm !== want.bpm ||
                got.gap_error !== want.gap_error || got.beat_index !== want.beat_index) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("[%0t] mismatch: expected new=%0d bpm=%0d err=%0d idx=%0d",
                             $realtime, want.bpm_new, want.bpm, want.gap_error,
                             want.beat_index);
                    $display("    got new=%0d bpm=%0d err=%0d idx=%0d",
                             got.bpm_new, got.bpm, got.gap_error, got.beat_index);
                end
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [GAP_W-1:0]       i_cfg_wdata;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata;   // [31:0] pulse_time_ms
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;   // [20:0] bpm, [25:21] beat_index
    logic [OUT_TUSER_W-1:0] o_m_axis_tuser;   // [0] bpm_new, [1] gap_error

    pulse_window_heart_rate_core #(.BEATS(WINDOW_BEATS)) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    t_pulse_rate_checker rate_chk;
    bit                  quiet_tail;
    logic [TIME_W-1:0]   edge_clock;
    int                  limits_used;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #8ms;
        $display("TB_ERROR");
        $finish;
    end

    // sink side stalls in bursts until the tail of the run
    initial begin
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                i_m_axis_tready = 1'b0;
                repeat ($urandom_range(0, 13)) @(negedge i_clk);
            end else begin
                i_m_axis_tready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_pulse_result got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.bpm_new    = o_m_axis_tuser[0];
            got.gap_error  = o_m_axis_tuser[1];
            got.bpm        = o_m_axis_tdata[BPM_W-1:0];
            got.beat_index = o_m_axis_tdata[BPM_W+CNT_W-1:BPM_W];
            rate_chk.match_result(got);
        end
    end

    task automatic send_pulse(input logic [TIME_W-1:0] t);
        @(negedge i_clk);
        if (!quiet_tail && $urandom_range(0, 6) == 0) begin
            i_s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = t;
        do @(posedge i_clk); while (!o_s_axis_tready);
        rate_chk.take_pulse(t);
        edge_clock = t;
    endtask

    // stop sending and let every owed result drain out
    task automatic drain_results();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (rate_chk.owed_results.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_gap_limit(input logic [GAP_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        rate_chk.gap_limit = v;
        limits_used++;
    endtask

    // mostly clean runs long enough to close a window, with restarts and jumps between
    task automatic run_pulses(input int n, input logic [GAP_W-1:0] lim);
        int          sent;
        int          run_len;
        logic [31:0] step;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(0, 3) != 0) begin
                run_len = $urandom_range(20, 24);
                if ($urandom_range(0, 5) == 0)
                    edge_clock = 32'hFFFF_FFFF - $urandom_range(0, 20 * lim);
                for (int k = 0; k < run_len; k++) begin
                    step = ($urandom_range(0, 7) == 0) ? lim : $urandom_range(0, lim);
                    send_pulse(edge_clock + step);
                end
                sent += run_len;
            end else begin
                run_len = $urandom_range(1, 4);
                for (int k = 0; k < run_len; k++) begin
                    case ($urandom_range(0, 2))
                        0: send_pulse(edge_clock + lim + 1);
                        1: send_pulse(edge_clock + lim + 1 + $urandom_range(0, 70000));
                        default: send_pulse($urandom());
                    endcase
                end
                sent += run_len;
            end
        end
    endtask

    initial begin
        logic [GAP_W-1:0] mid_limit;
        rate_chk = new();
        rate_chk.clear();
        quiet_tail      = 1'b0;
        limits_used     = 0;
        edge_clock      = '0;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // first edge far from time zero restarts, then a window with zero span
        send_pulse(32'hFFFF_FFFF);
        for (int k = 0; k < 21; k++)
            send_pulse(32'hFFFF_FFFF);
        // wrap with a gap exactly at the limit, then one just over it
        send_pulse(32'd1999);
        send_pulse(32'd4000);
        drain_results();

        write_gap_limit(16'hFFFF);
        run_pulses(250, 16'hFFFF);
        drain_results();

        write_gap_limit(16'd1);
        run_pulses(150, 16'd1);
        drain_results();

        // a zero limit rejects every nonzero gap
        write_gap_limit(16'd0);
        run_pulses(100, 16'd0);
        drain_results();

        mid_limit = GAP_W'($urandom_range(1, 65535));
        write_gap_limit(mid_limit);
        run_pulses(200, mid_limit);
        drain_results();

        write_gap_limit(GAP_RESET);
        quiet_tail = 1'b1;
        run_pulses(250, GAP_RESET);
        drain_results();

        $display("run covered %0d pulse edges under %0d gap limits", rate_chk.edges, limits_used);
        $display("%0d windows closed, %0d gap restarts, %0d mismatches",
                 rate_chk.windows, rate_chk.restarts, rate_chk.mismatches);
        if (rate_chk.mismatches == 0 && rate_chk.owed_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/pwhr_pkg.sv
hdl/pulse_window_heart_rate_core.sv
tb/sv/pulse_window_heart_rate_core_tb.sv
